// File: design/assert_macros.svh
// Assertion macros used by the hash table core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DHT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hash table assertion failed");

// next-cycle implication
`define DHT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hash table assertion failed");

`else

`define DHT_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DHT_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: design/dht_pkg.sv
// Types and constants of the digest dedup hash table
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

  localparam int HASH_W   = 32;
  localparam int STEP_W   = $clog2(HASH_W);
  localparam int CFG_W    = 13;
  localparam int INDEX_W  = 31;
  localparam int DIGEST_W = 64;

  localparam logic [CFG_W-1:0] SIZE_RESET = 13'd4093;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NOP    = 2'd3
  } dht_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_READ,
    S_CHECK,
    S_DONE
  } dht_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [HASH_W-1:0]  digest_word0;
    logic [HASH_W-1:0]  digest_word1;
    logic [HASH_W-1:0]  digest_word2;
    logic [HASH_W-1:0]  digest_word3;
    logic [INDEX_W-1:0] sector_index;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] source_index;
    logic               collided;
    logic               table_full;
  } out_word_t;

  typedef struct packed {
    logic                used;
    logic [DIGEST_W-1:0] digest_hi;
    logic [DIGEST_W-1:0] digest_lo;
    logic [INDEX_W-1:0]  source_index;
  } slot_entry_t;

endpackage

`default_nettype wire

// File: design/dht_if.sv
// Valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
`default_nettype none

interface dht_in_if;
  logic              valid;
  logic              ready;
  dht_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dht_out_if;
  logic               valid;
  logic               ready;
  dht_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/digest_dedup_hash_table_core.sv
// Top level: sequencer of the digest dedup hash table
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Open-addressing hash table for 128-bit sector digests with linear probing.
// One word is in flight at a time; in_ch.ready is high only between words.
// Insert and lookup first form the home slot in a bit-serial remainder
// unit, one dividend bit per cycle, as the digest XOR modulo the table
// size; each probed slot then takes a registered read of the slot
// memory and a compare (S_READ, S_CHECK), and S_DONE hands the result
// to the output register. Clear sweeps all TABLE_DEPTH slots, one per cycle,
// then returns an all-zero result; after reset the same sweep runs before
// the first word is taken. Mode 3 goes straight to S_DONE, returning zeros.
// A result may wait in the output register while the next word is already
// being worked on. table_size is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while the block is idle; it is not enforced.

module digest_dedup_hash_table_core #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [dht_pkg::CFG_W-1:0] cfg_wr_data,
  dht_in_if.sink                         in_ch,
  dht_out_if.source                      out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = (AW + 1 > dht_pkg::CFG_W) ? AW + 1 : dht_pkg::CFG_W;
  localparam logic [SW-1:0] DEPTH_S    = SW'(TABLE_DEPTH);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(TABLE_DEPTH - 1);

  dht_pkg::dht_state_t      state_r, state_nxt;
  logic [dht_pkg::CFG_W-1:0] table_size_r;
  dht_pkg::in_word_t        item_r, item_nxt;
  logic [AW-1:0]            sweep_r, sweep_nxt;
  logic                     clr_reply_r, clr_reply_nxt;
  logic [AW-1:0]            slot_r, slot_nxt;
  logic [SW-1:0]            probes_r, probes_nxt;
  dht_pkg::out_word_t       res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  dht_pkg::out_word_t       out_data_r, out_data_nxt;

  logic [SW-1:0]            cfg_ext;
  logic [SW-1:0]            size_eff;
  logic [SW-1:0]            probes_inc;
  logic [AW:0]              slot_inc;
  logic                     last_probe;
  logic                     hit;

  logic                     in_ready;
  logic                     mod_start;
  logic [dht_pkg::HASH_W-1:0] hash;
  logic                     mod_done;
  logic [SW-1:0]            mod_rem;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  dht_pkg::slot_entry_t     mem_wdata;
  dht_pkg::slot_entry_t     mem_rdata;

  // size 0 acts as 1, sizes above the depth saturate
  always_comb begin
    cfg_ext = SW'(table_size_r);
    if (cfg_ext == '0) begin
      size_eff = SW'(1);
    end else if (cfg_ext > DEPTH_S) begin
      size_eff = DEPTH_S;
    end else begin
      size_eff = cfg_ext;
    end
  end

  assign hash = in_ch.data.digest_word0 ^ in_ch.data.digest_word1 ^
                in_ch.data.digest_word2 ^ in_ch.data.digest_word3;

  assign probes_inc = probes_r + 1'b1;
  assign last_probe = probes_inc >= size_eff;
  assign slot_inc   = {1'b0, slot_r} + 1'b1;
  assign hit = (mem_rdata.digest_hi == {item_r.digest_word0, item_r.digest_word1}) &&
               (mem_rdata.digest_lo == {item_r.digest_word2, item_r.digest_word3});

  dht_mod_unit #(
    .DIV_W (SW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (hash),
    .divisor   (size_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  dht_slot_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (slot_r),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    sweep_nxt     = sweep_r;
    clr_reply_nxt = clr_reply_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = '0;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          res_nxt  = '0;
          case (in_ch.data.mode)
            dht_pkg::MODE_CLEAR: begin
              sweep_nxt     = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = dht_pkg::S_CLEAR;
            end
            dht_pkg::MODE_INSERT, dht_pkg::MODE_LOOKUP: begin
              mod_start = 1'b1;
              state_nxt = dht_pkg::S_MOD;
            end
            default: begin
              state_nxt = dht_pkg::S_DONE;
            end
          endcase
        end
      end
      dht_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) begin
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? dht_pkg::S_DONE : dht_pkg::S_IDLE;
        end
      end
      dht_pkg::S_MOD: begin
        if (mod_done) begin
          slot_nxt   = mod_rem[AW-1:0];
          probes_nxt = '0;
          state_nxt  = dht_pkg::S_READ;
        end
      end
      dht_pkg::S_READ: begin
        state_nxt = dht_pkg::S_CHECK;
      end
      dht_pkg::S_CHECK: begin
        state_nxt = dht_pkg::S_READ;
        if (SW'(slot_inc) >= size_eff) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_inc[AW-1:0];
        end
        probes_nxt = probes_inc;
        if (item_r.mode == dht_pkg::MODE_INSERT) begin
          if (!mem_rdata.used) begin
            mem_we                 = 1'b1;
            mem_wdata.used         = 1'b1;
            mem_wdata.digest_hi    = {item_r.digest_word0, item_r.digest_word1};
            mem_wdata.digest_lo    = {item_r.digest_word2, item_r.digest_word3};
            mem_wdata.source_index = item_r.sector_index;
            res_nxt.collided       = (probes_r != '0);
            state_nxt              = dht_pkg::S_DONE;
          end else if (last_probe) begin
            res_nxt.table_full = 1'b1;
            res_nxt.collided   = (size_eff != SW'(1));
            state_nxt          = dht_pkg::S_DONE;
          end
        end else begin
          if (!mem_rdata.used) begin
            state_nxt = dht_pkg::S_DONE;
          end else if (hit) begin
            res_nxt.found        = 1'b1;
            res_nxt.source_index = mem_rdata.source_index;
            state_nxt            = dht_pkg::S_DONE;
          end else if (last_probe) begin
            res_nxt.table_full = 1'b1;
            state_nxt          = dht_pkg::S_DONE;
          end
        end
      end
      dht_pkg::S_DONE: begin
        // load when the output register is empty or being drained this cycle
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = dht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dht_pkg::S_CLEAR;
      sweep_r      <= '0;
      clr_reply_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      table_size_r <= dht_pkg::SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        table_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    probes_r   <= probes_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `DHT_ASSERT_IMPL(a_mod_done_in_mod, clk, rst_n, mod_done, state_r == dht_pkg::S_MOD)
  `DHT_ASSERT_NEXT(a_mod_to_read, clk, rst_n, mod_done, state_r == dht_pkg::S_READ)
  `DHT_ASSERT_IMPL(a_slot_in_range, clk, rst_n, state_r == dht_pkg::S_READ, SW'(slot_r) < size_eff)
  `DHT_ASSERT_IMPL(a_probe_bound, clk, rst_n, state_r == dht_pkg::S_CHECK, probes_r < size_eff)

endmodule

`default_nettype wire

// File: design/dht_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module dht_mod_unit #(
  parameter int DIV_W = 13
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [dht_pkg::HASH_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]           divisor,
  output logic                            done,
  output logic [DIV_W-1:0]                remainder
);

  localparam logic [dht_pkg::STEP_W-1:0] LAST_STEP = dht_pkg::STEP_W'(dht_pkg::HASH_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [dht_pkg::STEP_W-1:0] step_r;
  logic [dht_pkg::HASH_W-1:0] dvd_r;
  logic [DIV_W-1:0]           dvs_r;
  logic [DIV_W-1:0]           rem_r;
  logic [DIV_W:0]             shifted;
  logic [DIV_W:0]             diff;
  logic [DIV_W-1:0]           rem_nxt;

  // rem_r < dvs_r always, so the shifted value stays below twice the divisor
  always_comb begin
    shifted = {rem_r, dvd_r[dht_pkg::HASH_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DIV_W-1:0];
    end else begin
      rem_nxt = shifted[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[dht_pkg::HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: design/dht_slot_mem.sv
// Slot store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module dht_slot_mem #(
  parameter int DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire dht_pkg::slot_entry_t      wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output dht_pkg::slot_entry_t           rdata
);

  dht_pkg::slot_entry_t mem [DEPTH];
  dht_pkg::slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: bench/digest_dedup_hash_table_core_tb.sv
// Testbench for the digest dedup hash table core: directed and random traffic
`timescale 1ns / 1ps

module digest_dedup_hash_table_core_tb;

  localparam int SLOT_COUNT    = 4096;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_WORDS  = 1030;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDX_W         = dht_pkg::INDEX_W;
  localparam int SIZE_W        = dht_pkg::CFG_W;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  dht_in_if  in_bus ();
  dht_out_if out_bus ();

  digest_dedup_hash_table_core #(
    .TABLE_DEPTH(SLOT_COUNT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch(in_bus),
    .out_ch(out_bus)
  );

  // shadow copy of the table
  bit                 shadow_used[SLOT_COUNT];
  logic [63:0]        shadow_hi[SLOT_COUNT];
  logic [63:0]        shadow_lo[SLOT_COUNT];
  logic [IDX_W-1:0]   shadow_index[SLOT_COUNT];
  logic [SIZE_W-1:0]  shadow_size;

  dht_pkg::out_word_t pending_results[$];
  logic [127:0]       known_digests[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 steady_phase;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Apply one word to the shadow table and return the result it produces.
  function automatic dht_pkg::out_word_t probe_table(input dht_pkg::in_word_t w);
    dht_pkg::out_word_t r;
    int unsigned size;
    int unsigned slot;
    int unsigned probes;
    logic [31:0] home;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          full;
    r = '0;
    size = 32'(shadow_size);
    if (size == 0) size = 1;
    if (size > SLOT_COUNT) size = SLOT_COUNT;
    hi = {w.digest_word0, w.digest_word1};
    lo = {w.digest_word2, w.digest_word3};
    home = w.digest_word0 ^ w.digest_word1 ^ w.digest_word2 ^ w.digest_word3;
    slot = home % size;
    case (w.mode)
      dht_pkg::MODE_CLEAR: begin
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      end
      dht_pkg::MODE_INSERT: begin
        full = 1'b1;
        for (probes = 0; probes < size; probes++) begin
          if (!shadow_used[slot]) begin
            shadow_used[slot]  = 1'b1;
            shadow_hi[slot]    = hi;
            shadow_lo[slot]    = lo;
            shadow_index[slot] = w.sector_index;
            full = 1'b0;
            break;
          end
          slot = (slot + 1 >= size) ? 0 : slot + 1;
        end
        r.table_full = full;
        // a full single-slot table probed only its home slot
        r.collided = full ? (size > 1) : (probes > 0);
      end
      dht_pkg::MODE_LOOKUP: begin
        full = 1'b1;
        for (probes = 0; probes < size; probes++) begin
          if (!shadow_used[slot]) begin
            full = 1'b0;
            break;
          end
          if (shadow_hi[slot] == hi && shadow_lo[slot] == lo) begin
            r.found = 1'b1;
            r.source_index = shadow_index[slot];
            full = 1'b0;
            break;
          end
          slot = (slot + 1 >= size) ? 0 : slot + 1;
        end
        r.table_full = full;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dht_pkg::in_word_t make_word(input dht_pkg::dht_mode_t m,
                                                  input logic [127:0] d,
                                                  input logic [IDX_W-1:0] idx);
    dht_pkg::in_word_t w;
    w.mode = m;
    {w.digest_word0, w.digest_word1, w.digest_word2, w.digest_word3} = d;
    w.sector_index = idx;
    return w;
  endfunction

  // digest whose four words XOR to the given home value
  function automatic logic [127:0] digest_for_home(input logic [31:0] home,
                                                   input logic [31:0] salt);
    return {home ^ salt, salt, 32'h0, 32'h0};
  endfunction

  function automatic logic [127:0] random_digest();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // valid stays high across back-to-back words; it drops for a gap or while draining
  task automatic send_word(input dht_pkg::in_word_t w);
    int gap;
    gap = steady_phase ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(probe_table(w));
  endtask

  task automatic wait_until_drained();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [SIZE_W-1:0] size);
    wait_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_size = size;
  endtask

  task automatic check_result(input dht_pkg::out_word_t got);
    dht_pkg::out_word_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected, actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
        mismatch_count++;
      end
      if (got.source_index !== want.source_index) begin
        $display("%0t: source_index expected %0d actual %0d", $time,
                 want.source_index, got.source_index);
        mismatch_count++;
      end
      if (got.collided !== want.collided) begin
        $display("%0t: collided expected %0d actual %0d", $time, want.collided,
                 got.collided);
        mismatch_count++;
      end
      if (got.table_full !== want.table_full) begin
        $display("%0t: table_full expected %0d actual %0d", $time, want.table_full,
                 got.table_full);
        mismatch_count++;
      end
    end
  endtask

  initial begin : result_monitor
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_phase ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      check_result(out_bus.data);
    end
  end

  task automatic test_reset_defaults();
    send_word(make_word(dht_pkg::MODE_INSERT, '1, 31'h7FFFFFFF));
    send_word(make_word(dht_pkg::MODE_LOOKUP, '1, '0));
    send_word(make_word(dht_pkg::MODE_INSERT, '0, '0));
    send_word(make_word(dht_pkg::MODE_LOOKUP, '0, '1));
    send_word(make_word(dht_pkg::MODE_LOOKUP, {32'hFFFFFFFF, 96'h0}, '0));
    send_word(make_word(dht_pkg::MODE_NOP, '1, '1));
    send_word(make_word(dht_pkg::MODE_NOP, '0, '0));
  endtask

  // size zero acts as one slot
  task automatic test_single_slot();
    logic [127:0] first;
    logic [127:0] second;
    first  = random_digest();
    second = random_digest();
    set_table_size('0);
    send_word(make_word(dht_pkg::MODE_INSERT, first, 31'd5));
    send_word(make_word(dht_pkg::MODE_INSERT, second, 31'd6));
    send_word(make_word(dht_pkg::MODE_LOOKUP, first, '0));
    send_word(make_word(dht_pkg::MODE_LOOKUP, second, '0));
    set_table_size(13'd1);
    send_word(make_word(dht_pkg::MODE_CLEAR, random_digest(), IDX_W'($urandom())));
    send_word(make_word(dht_pkg::MODE_LOOKUP, second, '0));
  endtask

  task automatic test_wraparound_and_full();
    set_table_size(13'd2);
    send_word(make_word(dht_pkg::MODE_CLEAR, '0, '0));
    send_word(make_word(dht_pkg::MODE_INSERT, digest_for_home(32'd1, 32'h11), 31'd100));
    send_word(make_word(dht_pkg::MODE_INSERT, digest_for_home(32'd3, 32'h22), 31'd200));
    send_word(make_word(dht_pkg::MODE_INSERT, digest_for_home(32'd0, 32'h33), 31'd300));
    send_word(make_word(dht_pkg::MODE_LOOKUP, random_digest(), '0));
  endtask

  // oversize value saturates; shrinking without a clear strands entries
  task automatic test_resize_without_clear();
    logic [127:0] top_slot;
    top_slot = digest_for_home(32'd4095, 32'h5A5A5A5A);
    set_table_size(13'd8191);
    send_word(make_word(dht_pkg::MODE_INSERT, top_slot, 31'd4095));
    send_word(make_word(dht_pkg::MODE_LOOKUP, top_slot, '0));
    set_table_size(13'd4096);
    send_word(make_word(dht_pkg::MODE_LOOKUP, top_slot, '0));
    set_table_size(13'd5);
    send_word(make_word(dht_pkg::MODE_LOOKUP, top_slot, '0));
    send_word(make_word(dht_pkg::MODE_CLEAR, '1, '1));
  endtask

  task automatic test_random_traffic();
    int                sent;
    int                phase_words;
    int                pick;
    logic [127:0]      d;
    dht_pkg::in_word_t w;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) set_table_size(SIZE_W'($urandom_range(1, 48)));
      else if (pick < 78) set_table_size('0);
      else if (pick < 88) set_table_size(SIZE_W'($urandom_range(49, 8191)));
      else if (pick < 94) set_table_size(13'd4096);
      else set_table_size(13'd8191);
      steady_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_word(make_word(dht_pkg::MODE_CLEAR, random_digest(), IDX_W'($urandom())));
        known_digests.delete();
        sent++;
      end
      phase_words = $urandom_range(20, 60);
      repeat (phase_words) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 || known_digests.size() == 0) begin
          d = random_digest();
          known_digests.push_back(d);
          w = make_word(dht_pkg::MODE_INSERT, d, IDX_W'($urandom()));
        end else if (pick < 48) begin
          // duplicate insert takes a second slot
          d = known_digests[$urandom_range(0, known_digests.size() - 1)];
          w = make_word(dht_pkg::MODE_INSERT, d, IDX_W'($urandom()));
        end else if (pick < 80) begin
          d = known_digests[$urandom_range(0, known_digests.size() - 1)];
          w = make_word(dht_pkg::MODE_LOOKUP, d, IDX_W'($urandom()));
        end else if (pick < 93) begin
          w = make_word(dht_pkg::MODE_LOOKUP, random_digest(), IDX_W'($urandom()));
        end else if (pick < 96) begin
          w = make_word(dht_pkg::MODE_CLEAR, random_digest(), IDX_W'($urandom()));
          known_digests.delete();
        end else begin
          w = make_word(dht_pkg::MODE_NOP, random_digest(), IDX_W'($urandom()));
        end
        send_word(w);
        sent++;
      end
    end
  endtask

  initial begin
    steady_phase   = 1'b0;
    shadow_size    = dht_pkg::SIZE_RESET;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_single_slot();
    test_wraparound_and_full();
    test_resize_without_clear();
    test_random_traffic();

    wait_until_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
